// ===== design/lcs_pkg.sv =====
// Shared types, constants and helper functions for the line centroid steering unit.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package lcs_pkg;

  // Sensor array geometry.
  localparam int SENSORS = 32;
  localparam int WINDOW = 8;
  localparam int GROUP = 8;
  localparam int GROUPS = SENSORS / GROUP;
  localparam int STEP_W = $clog2(GROUPS);
  localparam int IDX_W = $clog2(SENSORS);
  localparam int WCNT_W = $clog2(WINDOW + 1);

  // Field and datapath widths.
  localparam int HW_W = 6;
  localparam int GSUM_W = 9;
  localparam int GLIT_W = 4;
  localparam int WSUM_W = 10;
  localparam int LIT_W = 6;
  localparam int NUM_W = 19;
  localparam int CNT_W = $clog2(NUM_W);
  localparam int POS_W = 15;
  localparam int ERR_W = 16;
  localparam int DEC_W = 3;
  localparam int HITS_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 15;

  // Position scale: 1000 / 2, because weights are kept in half units.
  localparam int POS_SCALE = 500;

  // Reset values of the configuration registers.
  localparam logic [POS_W-1:0] CENTER_RESET = 15'd12500;
  localparam logic [POS_W-1:0] DEADBAND_RESET = 15'd1000;
  localparam logic [HITS_W-1:0] HITS_RESET = 8'd3;

  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER   = 2'd0,
    REG_DEADBAND = 2'd1,
    REG_HITS     = 2'd2
  } cfg_reg_t;

  // Decision codes.
  typedef enum logic [DEC_W-1:0] {
    DEC_BOX         = 3'd0,
    DEC_RIGHT_TURN  = 3'd1,
    DEC_STEER_RIGHT = 3'd2,
    DEC_STEER_LEFT  = 3'd3,
    DEC_FORWARD     = 3'd4
  } decision_t;

  // Front state machine.
  typedef enum logic [1:0] {
    F_IDLE,
    F_SUM,
    F_PUSH
  } front_state_t;

  // Back state machine.
  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_t;

  // One classified frame as it travels from front to back.
  typedef struct packed {
    logic              box;
    logic              turn;
    logic [WSUM_W-1:0] wsum;
    logic [LIT_W-1:0]  lit;
  } lcs_item_t;

  // Weight of sensor i in half units.
  function automatic logic [HW_W-1:0] half_weight(input logic [IDX_W-1:0] i);
    logic [HW_W-1:0] iw;
    iw = HW_W'(i);
    if (i < IDX_W'(8)) begin
      return (iw + HW_W'(1)) << 1;
    end else if (i < IDX_W'(24)) begin
      return iw + HW_W'(8);
    end else begin
      return (iw - HW_W'(7)) << 1;
    end
  endfunction

  // Number of set bits in a window of sensors.
  function automatic logic [WCNT_W-1:0] window_count(input logic [WINDOW-1:0] bits);
    logic [WCNT_W-1:0] c;
    c = '0;
    for (int k = 0; k < WINDOW; k++) begin
      c = c + WCNT_W'(bits[k]);
    end
    return c;
  endfunction

endpackage

// ===== design/lcs_front.sv =====
// Front part: takes sensor frame transfers, forms the weighted sum and lit count over
// four group steps, classifies box and right turn, and pushes the result to the queue.
// Depends on lcs_pkg.
`timescale 1ns / 1ps

module lcs_front
  import lcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [SENSORS-1:0] sensor_bits,
  input  logic [HITS_W-1:0] required_hits,
  input  logic              q_full,
  output logic              q_push,
  output lcs_item_t         q_item
);

  front_state_t      state;
  front_state_t      state_next;
  logic [SENSORS-1:0] frame_bits;
  logic [STEP_W-1:0] step;
  logic [WSUM_W-1:0] wsum;
  logic [LIT_W-1:0]  lit;
  logic [HITS_W-1:0] run_count;

  logic [GSUM_W-1:0] grp_wsum;
  logic [GLIT_W-1:0] grp_lit;
  logic [GROUP-1:0]  grp_bits;
  logic              box;
  logic              cand;
  logic              turn;
  logic [HITS_W-1:0] run_inc;
  logic [HITS_W-1:0] need;
  logic [HITS_W-1:0] run_count_next;
  logic              in_xfer;

  assign in_xfer = in_valid && !in_stall;

  // Weighted sum and lit count of the current group of eight sensors.
  always_comb begin
    grp_bits = frame_bits[{step, 3'b000} +: GROUP];
    grp_wsum = '0;
    grp_lit = '0;
    for (int k = 0; k < GROUP; k++) begin
      if (grp_bits[k]) begin
        grp_wsum = grp_wsum + GSUM_W'(half_weight({step, 3'(k)}));
        grp_lit = grp_lit + GLIT_W'(1);
      end
    end
  end

  // Box and right-turn classification with the consecutive-frame counter.
  always_comb begin
    box = window_count(frame_bits[WINDOW-1:0]) >= WCNT_W'(WINDOW - 1);
    cand = window_count(frame_bits[SENSORS-1 -: WINDOW]) >= WCNT_W'(WINDOW - 1);
    need = (required_hits == '0) ? HITS_W'(1) : required_hits;
    run_inc = '0;
    if (cand) begin
      run_inc = (run_count == '1) ? run_count : run_count + HITS_W'(1);
    end
    turn = 1'b0;
    run_count_next = run_inc;
    if (box) begin
      run_count_next = '0;
    end else if (run_inc >= need) begin
      turn = 1'b1;
      run_count_next = '0;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (in_xfer) state_next = F_SUM;
      end
      F_SUM: begin
        if (step == STEP_W'(GROUPS - 1)) state_next = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall = (state != F_IDLE);
    q_push = (state == F_PUSH) && !q_full;
    q_item.box = box;
    q_item.turn = turn;
    q_item.wsum = wsum;
    q_item.lit = lit;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      run_count <= '0;
    end else begin
      state <= state_next;
      if (q_push) run_count <= run_count_next;
    end
  end

  // Frame and accumulators.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      frame_bits <= sensor_bits;
      step <= '0;
      wsum <= '0;
      lit <= '0;
    end else if (state == F_SUM) begin
      step <= step + STEP_W'(1);
      wsum <= wsum + WSUM_W'(grp_wsum);
      lit <= lit + LIT_W'(grp_lit);
    end
  end

endmodule

// ===== design/lcs_queue.sv =====
// Short first-in first-out queue of classified frames between front and back.
// Depends on lcs_pkg for the item type.
`timescale 1ns / 1ps

module lcs_queue
  import lcs_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  lcs_item_t push_item,
  output logic      full,
  input  logic      pop,
  output lcs_item_t head,
  output logic      empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);

  lcs_item_t         entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  assign full = (fill == FILL_W'(DEPTH));
  assign empty = (fill == '0);
  assign head = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (fill == $past(fill) + FILL_W'(1)))
    else $error("queue fill level did not follow a lone push");
`endif

endmodule

// ===== design/lcs_back.sv =====
// Back part: pops classified frames, divides the scaled weighted sum by the lit count
// one quotient bit per cycle, and forms position, error and decision in the output register.
// Depends on lcs_pkg.
`timescale 1ns / 1ps

module lcs_back
  import lcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  lcs_item_t        q_item,
  output logic             q_pop,
  input  logic [POS_W-1:0] center,
  input  logic [POS_W-1:0] deadband,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [DEC_W-1:0] decision,
  output logic [POS_W-1:0] position,
  output logic signed [ERR_W-1:0] error
);

  back_state_t       state;
  back_state_t       state_next;
  logic [NUM_W-1:0]  quo;
  logic [LIT_W-1:0]  rem;
  logic [LIT_W-1:0]  divisor;
  logic [CNT_W-1:0]  cnt;
  logic              box;
  logic              turn;

  logic [LIT_W:0]    trial;
  logic              ge;
  logic [LIT_W-1:0]  rem_next;
  logic [POS_W-1:0]  pos_calc;
  logic signed [ERR_W-1:0] err_calc;
  logic signed [ERR_W-1:0] db;
  decision_t         dec_calc;
  logic              out_load;

  // One restoring division step.
  always_comb begin
    trial = {rem, quo[NUM_W-1]};
    ge = trial >= {1'b0, divisor};
    rem_next = ge ? LIT_W'(trial - {1'b0, divisor}) : trial[LIT_W-1:0];
  end

  // Position, error and steering decision from the finished quotient.
  always_comb begin
    pos_calc = (divisor == '0) ? '0 : quo[POS_W-1:0];
    err_calc = $signed({1'b0, pos_calc}) - $signed({1'b0, center});
    db = $signed({1'b0, deadband});
    if (box) begin
      dec_calc = DEC_BOX;
    end else if (turn) begin
      dec_calc = DEC_RIGHT_TURN;
    end else if (err_calc > db) begin
      dec_calc = DEC_STEER_RIGHT;
    end else if (err_calc < -db) begin
      dec_calc = DEC_STEER_LEFT;
    end else begin
      dec_calc = DEC_FORWARD;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) state_next = B_DIV;
      end
      B_DIV: begin
        if (cnt == '0) state_next = B_DONE;
      end
      B_DONE: begin
        if (!out_valid || !out_stall) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    q_pop = (state == B_IDLE) && !q_empty;
    out_load = (state == B_DONE) && (!out_valid || !out_stall);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Divider datapath.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      quo <= NUM_W'(q_item.wsum * POS_SCALE);
      rem <= '0;
      divisor <= q_item.lit;
      cnt <= CNT_W'(NUM_W - 1);
      box <= q_item.box;
      turn <= q_item.turn;
    end else if (state == B_DIV) begin
      quo <= {quo[NUM_W-2:0], ge};
      rem <= rem_next;
      cnt <= cnt - CNT_W'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      decision <= dec_calc;
      position <= pos_calc;
      error <= err_calc;
    end
  end

endmodule

// ===== design/line_centroid_steering_unit.sv =====
// Top level of the line centroid steering unit: configuration registers, front,
// queue and back. Depends on lcs_pkg, lcs_front, lcs_queue and lcs_back.
`timescale 1ns / 1ps

// Each sensor frame transfer yields exactly one result: the centroid position of the lit
// sensors times 1000 (zero when none is lit), its error from the configured center, and a
// decision that ranks box stop over right turn over deadband steering. The front takes a
// frame, sums it in four group steps of eight sensors and classifies it in the push state,
// and takes no new frame until it is pushed. The back pops a frame, divides its 19-bit
// quotient one bit per cycle and loads the result register, waiting in the done state
// while the output stalls; it takes no new frame before then, so the serial divider sets
// the sustained rate. A queue of QUEUE_DEPTH frames lets the front run ahead while a result
// waits to be taken. Configuration writes take effect at once and are meant for idle times.

module line_centroid_steering_unit
  import lcs_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SENSORS-1:0]    sensor_bits,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DEC_W-1:0]      decision,
  output logic [POS_W-1:0]      position,
  output logic signed [ERR_W-1:0] error
);

  logic [POS_W-1:0]  center;
  logic [POS_W-1:0]  deadband;
  logic [HITS_W-1:0] required_hits;

  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  lcs_item_t q_in;
  lcs_item_t q_head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      center <= CENTER_RESET;
      deadband <= DEADBAND_RESET;
      required_hits <= HITS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER:   center <= cfg_data;
        REG_DEADBAND: deadband <= cfg_data;
        REG_HITS:     required_hits <= cfg_data[HITS_W-1:0];
        default: ;
      endcase
    end
  end

  lcs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sensor_bits   (sensor_bits),
    .required_hits (required_hits),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_in)
  );

  lcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  lcs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .center    (center),
    .deadband  (deadband),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .decision  (decision),
    .position  (position),
    .error     (error)
  );

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for line_centroid_steering_unit: directed frames, then random ones.
// Depends on lcs_pkg and the design files; it reads nothing at run time.
`timescale 1ns / 1ps

module tb;
  import lcs_pkg::*;

  localparam int RESET_CYCLES = 5;
  localparam int DRAIN_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES = 9;
  localparam int FRAMES_PER_PHASE = 192;
  localparam int REPORT_LIMIT = 10;
  // Weights are kept in half units and positions in thousandths of a pitch.
  localparam int MILLI_PER_HALF = 500;
  localparam int RUN_TOP = 255;
  // Index past the last register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    decision_t                 dec;
    logic [POS_W-1:0]          pos;
    logic signed [ERR_W-1:0]   err;
  } steer_result_t;

  typedef struct packed {
    logic [SENSORS-1:0] bits;
    logic               typed;
    steer_result_t      want;
  } frame_row_t;

  localparam steer_result_t NO_RESULT = '0;
  localparam int DIRECTED_COUNT = 25;

  // Directed frames at the reset settings (center 12500, deadband 1000, three hits).
  localparam frame_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{32'h00000000, 1'b1, '{DEC_STEER_LEFT,  15'd0,     -16'sd12500}},
    '{32'hFFFFFFFF, 1'b1, '{DEC_BOX,         15'd12125, -16'sd375}},
    '{32'h00000001, 1'b1, '{DEC_STEER_LEFT,  15'd1000,  -16'sd11500}},
    '{32'h80000000, 1'b1, '{DEC_STEER_RIGHT, 15'd24000, 16'sd11500}},
    '{32'h00020000, 1'b1, '{DEC_FORWARD,     15'd12500, 16'sd0}},
    '{32'h00080000, 1'b1, '{DEC_FORWARD,     15'd13500, 16'sd1000}},
    '{32'h00100000, 1'b1, '{DEC_STEER_RIGHT, 15'd14000, 16'sd1500}},
    '{32'h00008000, 1'b1, '{DEC_FORWARD,     15'd11500, -16'sd1000}},
    '{32'h00004000, 1'b1, '{DEC_STEER_LEFT,  15'd11000, -16'sd1500}},
    '{32'h000000FE, 1'b0, NO_RESULT},
    '{32'h0000007F, 1'b1, '{DEC_BOX,         15'd4000,  -16'sd8500}},
    '{32'hFF000000, 1'b1, '{DEC_STEER_RIGHT, 15'd20500, 16'sd8000}},
    '{32'hFF000000, 1'b1, '{DEC_STEER_RIGHT, 15'd20500, 16'sd8000}},
    '{32'hFF000000, 1'b1, '{DEC_RIGHT_TURN,  15'd20500, 16'sd8000}},
    '{32'hFE000000, 1'b0, NO_RESULT},
    '{32'h7F000000, 1'b0, NO_RESULT},
    '{32'h00000000, 1'b0, NO_RESULT},
    '{32'hFF000000, 1'b0, NO_RESULT},
    '{32'hFF0000FF, 1'b1, '{DEC_BOX,         15'd12500, 16'sd0}},
    '{32'hFF000000, 1'b0, NO_RESULT},
    '{32'hFF000000, 1'b0, NO_RESULT},
    '{32'hFF00007F, 1'b0, NO_RESULT},
    '{32'h55555555, 1'b0, NO_RESULT},
    '{32'hAAAAAAAA, 1'b0, NO_RESULT},
    '{32'h00000103, 1'b0, NO_RESULT}
  };

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [SENSORS-1:0]      sensor_bits = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b1;
  logic [DEC_W-1:0]        decision;
  logic [POS_W-1:0]        position;
  logic signed [ERR_W-1:0] error;

  // Shadow copy of the steering settings and the right-turn run counter.
  logic [POS_W-1:0]  steer_center = CENTER_RESET;
  logic [POS_W-1:0]  steer_deadband = DEADBAND_RESET;
  logic [HITS_W-1:0] turn_hits = HITS_RESET;
  int unsigned       right_run = 0;

  steer_result_t pending_steering [$];
  int            fault_count = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            hold_requests = 0;
  int            holds_served = 0;
  int            hold_left = 0;
  int            quiet_cycles = 0;

  line_centroid_steering_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sensor_bits (sensor_bits),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .decision    (decision),
    .position    (position),
    .error       (error)
  );

  always #1 clk = ~clk;

  // Centroid, error and decision for one frame; advances the run counter.
  function automatic steer_result_t predict_steering(input logic [SENSORS-1:0] bits);
    steer_result_t r;
    int unsigned   wsum;
    int unsigned   lit;
    int unsigned   low_cnt;
    int unsigned   high_cnt;
    int unsigned   hw;
    int unsigned   need;
    int            pos_val;
    int            e;
    int            db;
    int            i;
    wsum = 0;
    lit = 0;
    low_cnt = 0;
    high_cnt = 0;
    for (i = 0; i < SENSORS; i++) begin
      if (i < 8) begin
        hw = 2 * (i + 1);
      end else if (i < 24) begin
        hw = 8 + i;
      end else begin
        hw = 2 * (i - 7);
      end
      if (bits[i]) begin
        wsum += hw;
        lit++;
        if (i < WINDOW) low_cnt++;
        if (i >= SENSORS - WINDOW) high_cnt++;
      end
    end
    pos_val = (lit == 0) ? 0 : int'((MILLI_PER_HALF * wsum) / lit);
    e = pos_val - int'(steer_center);
    db = int'(steer_deadband);
    need = (turn_hits == 0) ? 1 : turn_hits;
    r.pos = POS_W'(pos_val);
    r.err = ERR_W'(e);
    if (low_cnt >= WINDOW - 1) begin
      right_run = 0;
      r.dec = DEC_BOX;
    end else begin
      if (high_cnt >= WINDOW - 1) begin
        if (right_run < RUN_TOP) right_run++;
      end else begin
        right_run = 0;
      end
      if (right_run >= need) begin
        right_run = 0;
        r.dec = DEC_RIGHT_TURN;
      end else if (e > db) begin
        r.dec = DEC_STEER_RIGHT;
      end else if (e < -db) begin
        r.dec = DEC_STEER_LEFT;
      end else begin
        r.dec = DEC_FORWARD;
      end
    end
    return r;
  endfunction

  // Offer one frame until it transfers; valid stays high for a following frame.
  task automatic send_frame(input logic [SENSORS-1:0] bits, input logic typed = 1'b0,
                            input steer_result_t fixed = '0);
    steer_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sensor_bits <= bits;
    do @(posedge clk); while (in_stall);
    predicted = predict_steering(bits);
    pending_steering.push_back(typed ? fixed : predicted);
  endtask

  task automatic wait_drained();
    while (pending_steering.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_CENTER: steer_center = data;
      REG_DEADBAND: steer_deadband = data;
      REG_HITS: turn_hits = data[HITS_W-1:0];
      default: ;
    endcase
  endtask

  // Top byte with at least seven lit sensors; the low byte kept sparse.
  function automatic logic [SENSORS-1:0] candidate_frame();
    logic [7:0] top;
    logic [7:0] low;
    top = 8'hFF;
    if ($urandom_range(1)) top &= ~(8'h01 << $urandom_range(7));
    low = 8'($urandom & $urandom);
    return {top, 16'($urandom), low};
  endfunction

  function automatic logic [SENSORS-1:0] box_frame();
    logic [7:0] low;
    low = 8'hFF;
    if ($urandom_range(1)) low &= ~(8'h01 << $urandom_range(7));
    return {24'($urandom), low};
  endfunction

  // Half well-formed right-turn runs and boxes with random content, the rest noise.
  task automatic send_random_frames(input int budget);
    int          sent;
    int          run_len;
    int          k;
    int          kind;
    int unsigned need;
    logic [SENSORS-1:0] bits;
    sent = 0;
    need = (turn_hits == 0) ? 1 : turn_hits;
    while (sent < budget) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        run_len = $urandom_range(1) ? int'(need) : $urandom_range(need + 1, 1);
        for (k = 0; k < run_len; k++) begin
          send_frame(candidate_frame());
          sent++;
        end
      end else begin
        if (kind < 50) begin
          bits = box_frame();
        end else if (kind < 70) begin
          bits = 32'h1 << $urandom_range(SENSORS - 1);
          if ($urandom_range(1)) bits |= 32'h1 << $urandom_range(SENSORS - 1);
        end else if (kind < 75) begin
          bits = $urandom_range(1) ? '1 : '0;
        end else begin
          bits = $urandom;
        end
        send_frame(bits);
        sent++;
      end
    end
    in_valid <= 1'b0;
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each result transfer with the oldest pending prediction.
  always @(posedge clk) begin
    steer_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_steering.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT) begin
          $display("unexpected result: decision %0d position %0d error %0d",
                   decision, position, error);
        end
      end else begin
        want = pending_steering.pop_front();
        if (decision !== want.dec || position !== want.pos || error !== want.err) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT) begin
            $display("mismatch: decision %0d/%0d position %0d/%0d error %0d/%0d (exp/act)",
                     want.dec, decision, want.pos, position, want.err, error);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[line_centroid_steering_unit] ERROR");
      $finish;
    end
  end

  // Main sequence: reset, directed frames, then random phases at several settings.
  initial begin
    int row;
    int phase;
    int unsigned hits_val;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 24;
    recv_idle_pct = 73;
    @(posedge clk);

    for (row = 0; row < DIRECTED_COUNT; row++) begin
      send_frame(DIRECTED_ROWS[row].bits, DIRECTED_ROWS[row].typed, DIRECTED_ROWS[row].want);
    end
    in_valid <= 1'b0;

    for (phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          write_reg(REG_CENTER, 15'd12000);
          write_reg(REG_DEADBAND, 15'd500);
          hits_val = 1;
        end
        1: begin
          write_reg(REG_CENTER, 15'd0);
          write_reg(REG_DEADBAND, 15'd0);
          hits_val = 255;
        end
        2: begin
          write_reg(REG_CENTER, 15'd24000);
          write_reg(REG_DEADBAND, 15'd24000);
          hits_val = 2;
        end
        3: begin
          // Settings past the documented range, and zero hits acting as one.
          write_reg(REG_CENTER, 15'd32767);
          write_reg(REG_DEADBAND, 15'd32767);
          hits_val = 0;
        end
        default: begin
          write_reg(REG_CENTER, 15'($urandom_range(24000)));
          write_reg(REG_DEADBAND, 15'($urandom_range(4000)));
          hits_val = $urandom_range(6, 1);
        end
      endcase
      // Upper data bits are random; only the low byte holds the hit count.
      write_reg(REG_HITS, {7'($urandom), 8'(hits_val)});
      if (phase == 4) write_reg(REG_UNUSED, 15'($urandom));
      cfg_we <= 1'b0;

      if (phase >= 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (phase >= 3) begin
        send_idle_pct = 73;
        recv_idle_pct = 24;
      end
      // Long receiver hold-off while frames keep coming, to back up the input.
      if (phase == 6) hold_requests++;
      send_random_frames(FRAMES_PER_PHASE);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    fault_count += pending_steering.size();
    if (fault_count == 0) begin
      $display("[line_centroid_steering_unit] OK");
    end else begin
      $display("[line_centroid_steering_unit] ERROR");
    end
    $finish;
  end

endmodule
